// ===== rtl/core/htu_pkg.sv =====
// Shared types, constants and helper functions of the 4x4 homogeneous transform unit.
// Used by the processing cell, the step sequencer and the top level.
// No dependencies.
package htu_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ELEM_W    = 32;
   localparam int PROD_W    = 2 * ELEM_W - FRAC_BITS;
   localparam int ACC_W     = PROD_W + 2;

   localparam logic signed [ELEM_W-1:0] FX_ONE = ELEM_W'(64'sd1 <<< FRAC_BITS);
   localparam logic signed [ELEM_W-1:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [ELEM_W-1:0] S32_MIN = 32'sh8000_0000;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic [3:0][ELEM_W-1:0]   row_type;

   typedef enum logic [3:0] {
      OP_LOAD_CUR  = 4'd0,
      OP_LOAD_OPR  = 4'd1,
      OP_IDENTITY  = 4'd2,
      OP_TRANSPOSE = 4'd3,
      OP_SCALE     = 4'd4,
      OP_TRANSLATE = 4'd5,
      OP_COMPOSE   = 4'd6,
      OP_TRANSFORM = 4'd7,
      OP_READ      = 4'd8
   } htu_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } htu_state_type;

   // One step of work as issued by the sequencer.
   typedef struct packed {
      logic       single;     // unscheduled operation executes now
      logic       ring_load;  // cells load the ring from column res_col
      logic       ring_shift; // ring moves one cell up the chain
      logic       mul_en;
      logic       mul_src;    // 0: current element times vector, 1: operand times ring
      logic [1:0] k;          // element index fed to the multiplier
      logic       acc_en;
      logic       acc_first;
      logic       res_wr;     // clamped sum written back into column res_col
      logic [1:0] res_col;
      logic       capture;    // transform results are complete
   } htu_step_type;

   // Per-cell control word.
   typedef struct packed {
      logic [3:0] cur_mask;
      logic [3:0] opr_mask;
      logic       ring_load;
      logic       ring_shift;
      logic       mul_en;
      logic       mul_src;
      logic [1:0] a_sel;
      logic       acc_en;
      logic       acc_first;
      logic       res_wr;
      logic [1:0] res_col;
   } htu_cell_ctl_type;

   typedef struct packed {
      logic     sat;
      elem_type val;
   } htu_clamp_type;

   function automatic htu_clamp_type sat32(input logic signed [ACC_W-1:0] v);
      htu_clamp_type r;
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(S32_MAX);
      lo = ACC_W'(S32_MIN);
      if (v > hi) begin
         r.sat = 1'b1;
         r.val = S32_MAX;
      end else if (v < lo) begin
         r.sat = 1'b1;
         r.val = S32_MIN;
      end else begin
         r.sat = 1'b0;
         r.val = ELEM_W'(v);
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/htu_cell.sv =====
// One row cell of the transform chain: a row of the current and operand matrices,
// a multiplier, an accumulator and one ring register shared with its neighbor.
// Depends on htu_pkg.
module htu_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  htu_pkg::htu_cell_ctl_type ctl,
   input  htu_pkg::row_type          row_data,
   input  htu_pkg::elem_type         vec_val,
   input  logic [31:0]               ring_nb,
   output htu_pkg::row_type          cur_row,
   output logic [31:0]               ring_out,
   output htu_pkg::elem_type         clamp_val,
   output logic                      clamp_sat
);
   import htu_pkg::*;

   row_type                  cur_ff, cur_in;
   row_type                  opr_ff, opr_in;
   logic [ELEM_W-1:0]        ring_ff, ring_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   elem_type                 a_val, b_val;
   logic signed [63:0]       prod_full;
   htu_clamp_type            clamp;

   always_comb begin
      a_val     = ctl.mul_src ? opr_ff[ctl.a_sel] : cur_ff[ctl.a_sel];
      b_val     = ctl.mul_src ? ring_ff : vec_val;
      prod_full = 64'(a_val) * 64'(b_val);
      // Arithmetic shift gives the floor of the scaled product.
      prod_in   = ctl.mul_en ? PROD_W'(prod_full >>> FRAC_BITS) : prod_ff;
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctl.acc_en) begin
         acc_in = (ctl.acc_first ? '0 : acc_ff) + ACC_W'(prod_ff);
      end
   end

   assign clamp = sat32(acc_ff);

   always_comb begin
      for (int e = 0; e < 4; e++) begin
         if (ctl.res_wr && (ctl.res_col == 2'(e))) begin
            cur_in[e] = clamp.val;
         end else if (ctl.cur_mask[e]) begin
            cur_in[e] = row_data[e];
         end else begin
            cur_in[e] = cur_ff[e];
         end
         opr_in[e] = ctl.opr_mask[e] ? row_data[e] : opr_ff[e];
      end
   end

   always_comb begin
      if (ctl.ring_load) begin
         ring_in = cur_ff[ctl.res_col];
      end else if (ctl.ring_shift) begin
         ring_in = ring_nb;
      end else begin
         ring_in = ring_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
         opr_ff <= '0;
      end else begin
         cur_ff <= cur_in;
         opr_ff <= opr_in;
      end
   end

   always_ff @(posedge clock) begin
      ring_ff <= ring_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign cur_row   = cur_ff;
   assign ring_out  = ring_ff;
   assign clamp_val = clamp.val;
   assign clamp_sat = clamp.sat;

endmodule

// ===== rtl/core/htu_seq.sv =====
// Step sequencer of the transform unit: state machine and phase counters that issue
// one step word per cycle for the operation held by the top level.
// Depends on htu_pkg.
module htu_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  htu_pkg::htu_op_type   op,
   input  logic                  rsp_free,
   output htu_pkg::htu_step_type step,
   output logic                  idle,
   output logic                  finish
);
   import htu_pkg::*;

   htu_state_type state_ff, state_in;
   logic [2:0]    p_ff, p_in;
   logic [1:0]    j_ff, j_in;
   logic          last;

   // Schedule of the multi-cycle operations.
   always_comb begin
      step = '0;
      last = 1'b0;
      if (state_ff == ST_RUN) begin
         case (op)
            OP_COMPOSE: begin
               step.ring_load  = (p_ff == 3'd0);
               step.mul_en     = (p_ff >= 3'd1) && (p_ff <= 3'd4);
               step.ring_shift = step.mul_en;
               step.mul_src    = 1'b1;
               step.k          = 2'(p_ff - 3'd1);
               step.acc_en     = (p_ff >= 3'd2) && (p_ff <= 3'd5);
               step.acc_first  = (p_ff == 3'd2);
               step.res_wr     = (p_ff == 3'd6);
               step.res_col    = j_ff;
               last            = (p_ff == 3'd6) && (j_ff == 2'd3);
            end
            OP_TRANSFORM: begin
               step.mul_en    = (p_ff <= 3'd3);
               step.k         = 2'(p_ff);
               step.acc_en    = (p_ff >= 3'd1) && (p_ff <= 3'd4);
               step.acc_first = (p_ff == 3'd1);
               step.capture   = (p_ff == 3'd5);
               last           = (p_ff == 3'd5);
            end
            OP_SCALE: begin
               step.mul_en    = (p_ff == 3'd0);
               step.k         = j_ff;
               step.acc_en    = (p_ff == 3'd1);
               step.acc_first = 1'b1;
               step.res_wr    = (p_ff == 3'd2);
               step.res_col   = j_ff;
               last           = (p_ff == 3'd2) && (j_ff == 2'd3);
            end
            default: begin
               step.single = 1'b1;
               last        = 1'b1;
            end
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (last) state_in = rsp_free ? ST_IDLE : ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      idle   = 1'b0;
      finish = 1'b0;
      case (state_ff)
         ST_IDLE: idle   = 1'b1;
         ST_RUN:  finish = last && rsp_free;
         ST_HOLD: finish = rsp_free;
         default: idle   = 1'b0;
      endcase
   end

   always_comb begin
      p_in = p_ff;
      j_in = j_ff;
      if (state_ff != ST_RUN) begin
         p_in = '0;
         j_in = '0;
      end else if (!last) begin
         if ((op == OP_COMPOSE && p_ff == 3'd6) || (op == OP_SCALE && p_ff == 3'd2)) begin
            p_in = '0;
            j_in = j_ff + 2'd1;
         end else begin
            p_in = p_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         p_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         p_ff     <= p_in;
         j_ff     <= j_in;
      end
   end

endmodule

// ===== rtl/core/homogeneous_4x4_transform_unit.sv =====
// Top level of the 4x4 homogeneous matrix transform unit in signed Q16.16.
// Instantiates four htu_cell row cells and the htu_seq sequencer; depends on htu_pkg.
//
// Usage: each transfer on the req_ channel carries one operation in req_tuser and its
// row, column and x, y, z, w values in req_tdata. Every operation yields exactly one
// transfer on the rsp_ channel: the four result words in rsp_tdata and the saturation
// flag in rsp_tuser. Results other than transform and read return zero words.
// The unit works on one operation at a time. The result register is loaded after the
// request transfer once the operation's steps are done: for unscheduled operations
// (loads, identity, transpose, translate, read and unused codes) the step that executes
// them; for scale a multiply, an accumulate and a write-back per column; for transform
// four pipelined products, an accumulate drain and a capture; for compose, per result
// column, a ring load, four multiply steps along the ring, a drain and a write-back.
// A new request is taken in the cycle after the result is registered, even while that
// result still waits on rsp_tready; if the receiver stalls and the next operation is
// done, the unit holds that result internally until the output register frees up.
// Reset is synchronous and clears both matrices to zero and empties the output.
module homogeneous_4x4_transform_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [1:0] row, [3:2] col, [35:4] x_value, [67:36] y_value, [99:68] z_value,
   // [131:100] w_value, [135:132] zero
   input  logic [135:0]  req_tdata,
   // [3:0] operation
   input  logic [3:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [31:0] result_0, [63:32] result_1, [95:64] result_2, [127:96] result_3
   output logic [127:0]  rsp_tdata,
   // [0] saturated
   output logic [0:0]    rsp_tuser
);
   import htu_pkg::*;

   htu_op_type       op_ff, op_in;
   logic [1:0]       row_ff, row_in;
   logic [1:0]       col_ff, col_in;
   row_type          v_ff, v_in;
   logic             sat_ff, sat_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [127:0]     rsp_data_ff, rsp_data_in;
   logic             rsp_sat_ff, rsp_sat_in;

   logic             accept;
   logic             rsp_free;
   htu_step_type     step;
   logic             idle;
   logic             finish;

   htu_cell_ctl_type ctl      [4];
   row_type          row_data [4];
   elem_type         vec_val  [4];
   row_type          cur_row  [4];
   logic [31:0]      ring_out [4];
   elem_type         clamp_val[4];
   logic [3:0]       clamp_sat;
   logic [3:0]       cell_sat;

   row_type          trans_val;
   logic [2:0]       trans_sat;
   logic             step_sat;
   htu_clamp_type    tc;

   assign req_tready = idle;
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Request capture.
   always_comb begin
      op_in  = op_ff;
      row_in = row_ff;
      col_in = col_ff;
      v_in   = v_ff;
      if (accept) begin
         op_in   = htu_op_type'(req_tuser);
         row_in  = req_tdata[1:0];
         col_in  = req_tdata[3:2];
         v_in[0] = req_tdata[35:4];
         v_in[1] = req_tdata[67:36];
         v_in[2] = req_tdata[99:68];
         v_in[3] = req_tdata[131:100];
      end
   end

   htu_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .op       (op_ff),
      .rsp_free (rsp_free),
      .step     (step),
      .idle     (idle),
      .finish   (finish)
   );

   // Translate adds to row 3 directly, each sum clamped on its own.
   always_comb begin
      trans_val = cur_row[3];
      trans_sat = '0;
      tc        = '0;
      for (int e = 0; e < 3; e++) begin
         tc = sat32(ACC_W'($signed({cur_row[3][e][31], cur_row[3][e]})
                    + $signed({v_ff[e][31], v_ff[e]})));
         trans_val[e] = tc.val;
         trans_sat[e] = tc.sat;
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_cell
      localparam logic [1:0] IDX = 2'(i);
      localparam int         NB  = (i + 1) % 4;

      always_comb begin
         ctl[i]            = '0;
         row_data[i]       = '0;
         ctl[i].ring_load  = step.ring_load;
         ctl[i].ring_shift = step.ring_shift;
         ctl[i].mul_en     = step.mul_en;
         ctl[i].mul_src    = step.mul_src;
         // In compose, cell i meets row (i + k) of the current matrix on the ring.
         ctl[i].a_sel      = (op_ff == OP_COMPOSE) ? step.k + IDX : step.k;
         ctl[i].acc_en     = step.acc_en;
         ctl[i].acc_first  = step.acc_first;
         ctl[i].res_wr     = step.res_wr && !((op_ff == OP_SCALE) && (IDX == 2'd3));
         ctl[i].res_col    = step.res_col;
         vec_val[i]        = (op_ff == OP_SCALE) ? v_ff[i] : v_ff[step.k];
         if (step.single) begin
            case (op_ff)
               OP_LOAD_CUR: begin
                  ctl[i].cur_mask = (row_ff == IDX) ? 4'b0001 << col_ff : 4'b0000;
                  row_data[i]     = {4{v_ff[0]}};
               end
               OP_LOAD_OPR: begin
                  ctl[i].opr_mask = (row_ff == IDX) ? 4'b0001 << col_ff : 4'b0000;
                  row_data[i]     = {4{v_ff[0]}};
               end
               OP_IDENTITY: begin
                  ctl[i].cur_mask = 4'b1111;
                  row_data[i][i]  = FX_ONE;
               end
               OP_TRANSPOSE: begin
                  ctl[i].cur_mask = 4'b1111;
                  for (int e = 0; e < 4; e++) begin
                     row_data[i][e] = cur_row[e][i];
                  end
               end
               OP_TRANSLATE: begin
                  ctl[i].cur_mask = (IDX == 2'd3) ? 4'b0111 : 4'b0000;
                  row_data[i]     = trans_val;
               end
               default: ctl[i].cur_mask = 4'b0000;
            endcase
         end
      end

      htu_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl[i]),
         .row_data  (row_data[i]),
         .vec_val   (vec_val[i]),
         .ring_nb   (ring_out[NB]),
         .cur_row   (cur_row[i]),
         .ring_out  (ring_out[i]),
         .clamp_val (clamp_val[i]),
         .clamp_sat (clamp_sat[i])
      );

      assign cell_sat[i] = (ctl[i].res_wr || step.capture) && clamp_sat[i];
   end

   assign step_sat = (|cell_sat)
                     || (step.single && (op_ff == OP_TRANSLATE) && (|trans_sat));

   always_comb begin
      sat_in = accept ? 1'b0 : (sat_ff || step_sat);
   end

   // Result assembly; transform sums stay in the accumulators while the result waits.
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_sat_in   = sat_ff || step_sat;
         case (op_ff)
            OP_TRANSFORM: rsp_data_in = {clamp_val[3], clamp_val[2], clamp_val[1], clamp_val[0]};
            OP_READ:      rsp_data_in = {96'd0, cur_row[row_ff][col_ff]};
            default:      rsp_data_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sat_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sat_ff       <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      v_ff        <= v_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_sat_ff;

   // No work is issued to the cells while the unit waits for a request.
   a_idle_quiet : assert property (@(posedge clock) disable iff (reset)
      idle |-> (step == '0))
      else $error("step issued while idle");

   // A write-back never coincides with a new multiplication in the schedule.
   a_wr_no_mul : assert property (@(posedge clock) disable iff (reset)
      step.res_wr |-> !step.mul_en)
      else $error("write-back overlaps multiply");

   // A result is only registered when the output register can take it.
   a_finish_free : assert property (@(posedge clock) disable iff (reset)
      finish |-> rsp_free)
      else $error("result registered over a pending transfer");

   // An accepted request is being worked on in the next cycle.
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> !idle)
      else $error("request dropped after acceptance");

endmodule
